// ----- hdl/periodic_task_tick_scheduler_macros.svh -----
// Assertion macros for the periodic task tick scheduler.
// No dependencies; included by the top level only.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PTTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptts assertion failed");

// next-cycle implication, disabled in reset
`define PTTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptts assertion failed");

`endif

// ----- hdl/ptts_pkg.sv -----
// Shared types and codes for the periodic task tick scheduler.
// No dependencies.
package ptts_pkg;

	localparam logic [1:0] ACT_TICK     = 2'd0;
	localparam logic [1:0] ACT_REGISTER = 2'd1;
	localparam logic [1:0] ACT_SERVICE  = 2'd2;

	typedef struct packed {
		logic [2:0] task_index;
		logic       task_valid;
		logic       any_pending;
		logic       table_full;
		logic       last;
	} res_t;

endpackage

// ----- hdl/ptts_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ptts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/ptts_seq.sv -----
// Sequencer of the tick scheduler: walks the slot table, holds enable and
// pending bits, and drives the RAM of reload and count values. Uses ptts_pkg.
module ptts_seq
	import ptts_pkg::*;
#(
	parameter int NUM_TASKS  = 8,
	parameter int COUNT_BITS = 16,
	localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1,
	localparam int CW = $clog2(NUM_TASKS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [1:0]              action,
	input  logic [15:0]             reload_value,
	input  logic                    start_enabled,
	input  logic                    start_pending,
	output logic                    res_valid,
	input  logic                    res_ready,
	output res_t                    res,
	output logic                    ram_we,
	output logic [IW-1:0]           ram_waddr,
	output logic [2*COUNT_BITS-1:0] ram_wdata,
	output logic                    ram_re,
	output logic [IW-1:0]           ram_raddr,
	input  logic [2*COUNT_BITS-1:0] ram_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TICK = 4'b0010,
		ST_SERV = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        used_q;
	logic [CW-1:0]        idx_q;
	logic [NUM_TASKS-1:0] en_q;
	logic [NUM_TASKS-1:0] pend_q;
	logic                 flag_q;
	logic                 rd_s1;
	logic [IW-1:0]        idx_s1;
	logic                 held_q;
	logic [IW-1:0]        held_idx_q;
	logic                 before_q;
	res_t                 res_q;
	res_t                 res_d;

	logic                  accept;
	logic                  full;
	logic                  issue;
	logic                  wr_tick;
	logic [COUNT_BITS-1:0] reload_m;
	logic [COUNT_BITS-1:0] rd_reload;
	logic [COUNT_BITS-1:0] rd_count;
	logic                  cnt_zero;
	logic [COUNT_BITS-1:0] new_count;
	logic                  scan_ok;
	logic                  scan_hit;
	logic                  serv_step;

	assign accept    = item_valid && item_ready;
	assign full      = (used_q == CW'(NUM_TASKS));
	assign reload_m  = COUNT_BITS'(reload_value);
	assign rd_reload = ram_rdata[2*COUNT_BITS-1:COUNT_BITS];
	assign rd_count  = ram_rdata[COUNT_BITS-1:0];
	assign cnt_zero  = (rd_count == '0);
	assign new_count = cnt_zero ? rd_reload : rd_count - COUNT_BITS'(1);
	assign issue     = (state_q == ST_TICK) && (idx_q < used_q);
	assign wr_tick   = rd_s1 && en_q[idx_s1];
	assign scan_ok   = (idx_q < used_q);
	assign scan_hit  = scan_ok && pend_q[idx_q[IW-1:0]];
	// a second hit must first push out the one held back
	assign serv_step = (state_q == ST_SERV) && scan_ok && (!(scan_hit && held_q) || res_ready);

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		ram_re     = issue;
		ram_raddr  = idx_q[IW-1:0];
		if (wr_tick) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
			ram_wdata = {rd_reload, new_count};
		end else begin
			ram_we    = accept && (action == ACT_REGISTER) && !full;
			ram_waddr = used_q[IW-1:0];
			ram_wdata = {reload_m, reload_m};
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		unique case (state_q)
			ST_SERV: begin
				if (!scan_ok) begin
					res_valid        = 1'b1;
					res.task_index   = held_q ? 3'(held_idx_q) : 3'd0;
					res.task_valid   = held_q;
					res.any_pending  = before_q;
					res.last         = 1'b1;
				end else if (scan_hit && held_q) begin
					res_valid        = 1'b1;
					res.task_index   = 3'(held_idx_q);
					res.task_valid   = 1'b1;
					res.any_pending  = before_q;
				end
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				res       = res_q;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// single-word result for tick, register and spare codes
	always_comb begin
		res_d = res_q;
		if (accept) begin
			res_d      = '0;
			res_d.last = 1'b1;
			if (action == ACT_REGISTER) begin
				if (full) begin
					res_d.any_pending = flag_q;
					res_d.table_full  = 1'b1;
				end else begin
					res_d.task_index  = 3'(used_q);
					res_d.task_valid  = 1'b1;
					res_d.any_pending = flag_q | start_pending;
				end
			end else begin
				res_d.any_pending = flag_q;
			end
		end else if (state_q == ST_TICK && !issue && !rd_s1) begin
			// pending flag has taken the last write-back by now
			res_d.any_pending = flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			idx_q   <= '0;
			en_q    <= '0;
			pend_q  <= '0;
			flag_q  <= 1'b0;
			rd_s1   <= 1'b0;
			held_q  <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (wr_tick && cnt_zero) begin
				pend_q[idx_s1] <= 1'b1;
				flag_q         <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						held_q <= 1'b0;
						case (action)
							ACT_TICK: state_q <= ST_TICK;
							ACT_SERVICE: state_q <= ST_SERV;
							ACT_REGISTER: begin
								state_q <= ST_EMIT;
								if (!full) begin
									en_q[used_q[IW-1:0]]   <= start_enabled;
									pend_q[used_q[IW-1:0]] <= start_pending;
									flag_q                 <= flag_q | start_pending;
									used_q                 <= used_q + CW'(1);
								end
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_TICK: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end else if (!rd_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_SERV: begin
					if (serv_step) begin
						idx_q <= idx_q + CW'(1);
						if (scan_hit) begin
							pend_q[idx_q[IW-1:0]] <= 1'b0;
							held_q                <= 1'b1;
						end
					end
					if (!scan_ok && res_ready) begin
						flag_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= idx_q[IW-1:0];
		end
		if (serv_step && scan_hit) begin
			held_idx_q <= idx_q[IW-1:0];
		end
		if (accept) begin
			before_q <= flag_q;
		end
		res_q <= res_d;
	end

endmodule

// ----- hdl/periodic_task_tick_scheduler.sv -----
// Periodic task tick scheduler. One word is taken at a time. A tick word
// walks the used slots through the single read port of the count RAM, one
// slot a cycle, with each write-back in the cycle after its read. A service
// word scans the pending bits one slot a cycle while the result side does
// not stall. Results leave through a one-word output register.
// Depends on ptts_pkg, ptts_seq, ptts_ram and the assertion macros header.
`include "periodic_task_tick_scheduler_macros.svh"

module periodic_task_tick_scheduler
	import ptts_pkg::*;
#(
	parameter int NUM_TASKS  = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  action,
	input  logic [15:0] reload_value,
	input  logic        start_enabled,
	input  logic        start_pending,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  task_index,
	output logic        task_valid,
	output logic        any_pending,
	output logic        table_full,
	output logic        last
);

	localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	logic                    res_valid;
	logic                    res_ready;
	res_t                    res;
	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	logic [2*COUNT_BITS-1:0] ram_wdata;
	logic                    ram_re;
	logic [IW-1:0]           ram_raddr;
	logic [2*COUNT_BITS-1:0] ram_rdata;
	logic                    out_valid_q;
	res_t                    out_q;

	ptts_seq #(
		.NUM_TASKS (NUM_TASKS),
		.COUNT_BITS(COUNT_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.reload_value (reload_value),
		.start_enabled(start_enabled),
		.start_pending(start_pending),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	// reload value in the upper half, live count in the lower
	ptts_ram #(
		.WIDTH(2 * COUNT_BITS),
		.DEPTH(NUM_TASKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign res_ready = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign task_index   = out_q.task_index;
	assign task_valid   = out_q.task_valid;
	assign any_pending  = out_q.any_pending;
	assign table_full   = out_q.table_full;
	assign last         = out_q.last;

	`PTTS_ASSERT_NOW(a_idle_no_res, clk, arst_n, item_ready, !res_valid)
	`PTTS_ASSERT_NOW(a_invalid_idx_zero, clk, arst_n, res_valid && !res.task_valid,
		res.task_index == 3'd0 && res.last)
	`PTTS_ASSERT_NOW(a_full_shape, clk, arst_n, res_valid && res.table_full,
		!res.task_valid && res.last)
	`PTTS_ASSERT_NEXT(a_one_word, clk, arst_n, item_valid && item_ready, !item_ready)

endmodule
